@@ src/ptw_pkg.sv @@
// Package for the Sv39 page table walker: widths, codes, state type and helpers.
`default_nettype none

package ptw_pkg;

    // Table store geometry
    localparam int TABLE_FRAMES  = 64;
    localparam int ROOT_FRAMES   = 4;
    localparam int TABLE_ENTRIES = 512;

    localparam int IDX_W       = 9;
    localparam int FLAG_W      = 10;
    localparam int PPN_W       = 44;
    localparam int ENTRY_W     = PPN_W + FLAG_W;
    localparam int VA_W        = 39;
    localparam int PA_W        = 56;
    localparam int OFS_W       = 12;
    localparam int ROOT_SEL_W  = 2;
    localparam int STATUS_W    = 2;

    localparam int FRAME_W     = $clog2(TABLE_FRAMES);
    localparam int SLOT_W      = FRAME_W + IDX_W;
    localparam int STORE_DEPTH = TABLE_FRAMES * TABLE_ENTRIES;
    localparam int FREE_W      = $clog2(TABLE_FRAMES + 1);

    localparam logic [SLOT_W-1:0] STORE_LAST   = SLOT_W'(STORE_DEPTH - 1);
    localparam logic [FREE_W:0]   FRAMES_LIMIT = (FREE_W + 1)'(TABLE_FRAMES);
    localparam logic [FREE_W-1:0] FREE_RESET   = FREE_W'(ROOT_FRAMES);

    // Request kinds
    localparam logic REQ_MAP    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 2'd2;

    // Walk sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD2,
        S_CHK2,
        S_CHK1,
        S_CHK0,
        S_WR1,
        S_WR0,
        S_RESP
    } ptw_state_t;

    // Root frame: select value folded into the reserved root range
    function automatic logic [FRAME_W-1:0] root_frame(input logic [ROOT_SEL_W-1:0] sel);
        logic [4:0] r;
        r = {3'b000, sel};
        for (int i = 0; i < 3; i++) begin
            if (r >= 5'(ROOT_FRAMES)) begin
                r = r - 5'(ROOT_FRAMES);
            end
        end
        return FRAME_W'(r);
    endfunction

    // Index of one level taken from the virtual address
    function automatic logic [IDX_W-1:0] vpn(input logic [VA_W-1:0] va, input int level);
        return va[OFS_W + IDX_W * level +: IDX_W];
    endfunction

endpackage

`default_nettype wire

@@ src/ptw_if.sv @@
// Request and response channel interfaces of the page table walker.
`default_nettype none

interface ptw_req_if import ptw_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [FLAG_W-1:0] pte_flags;

    modport source (output valid, req_type, virt_addr, phys_addr, pte_flags, input ready);
    modport sink   (input valid, req_type, virt_addr, phys_addr, pte_flags, output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     translated_addr;
    logic [FLAG_W-1:0]   found_flags;

    modport source (output valid, status, translated_addr, found_flags, input ready);
    modport sink   (input valid, status, translated_addr, found_flags, output ready);
endinterface

`default_nettype wire

@@ src/ptw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/sv39_page_table_walker_core.sv @@
// Sv39 page table walker: top level with walk sequencer and table store.
//
// Usage
//   req channel: a map (req_type 0) or lookup (req_type 1) request with a 39-bit
//   virtual address, a 56-bit physical address and 10 leaf flags. rsp channel:
//   one response per request with status, translated address and found flags.
//   cfg_we/cfg_wdata set root_select; the user must write only while idle (unchecked).
// Timing
//   One request at a time. A lookup reads the level 2, 1 and 0 entries in turn
//   and stops at the first invalid one; a map links new tables where needed and
//   writes the leaf, while a refused map writes nothing.
// Reset
//   After rst_n releases, a clearing pass zeroes the table store one entry
//   per cycle, 32768 entries with the default 64 frames. req.ready stays low
//   until it ends; configuration writes are taken throughout.
// Stalls
//   A finished response sits in an output register; the next request is
//   accepted while it waits, and its walk holds at the end until the
//   register is free.
`default_nettype none

module sv39_page_table_walker_core import ptw_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ptw_req_if.sink                    req,
    ptw_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [ROOT_SEL_W-1:0] cfg_wdata
);

    ptw_state_t state_reg, state_next;

    logic [ROOT_SEL_W-1:0] root_sel_reg;
    logic [SLOT_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;

    // Latched request
    logic                  req_type_reg;
    logic [VA_W-1:0]       va_reg;
    logic [PPN_W-1:0]      pa_ppn_reg;
    logic [FLAG_W-1:0]     flags_reg;

    // Result awaiting the output register
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PA_W-1:0]       res_addr_reg, res_addr_next;
    logic [FLAG_W-1:0]     res_flags_reg, res_flags_next;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [PA_W-1:0]       out_addr_reg;
    logic [FLAG_W-1:0]     out_flags_reg;

    // Table store port
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [SLOT_W-1:0]     mem_raddr;
    logic [ENTRY_W-1:0]    mem_rdata;

    logic                  req_fire;
    logic                  out_free;
    logic                  ent_valid;
    logic [FRAME_W-1:0]    ent_child;
    logic [FRAME_W-1:0]    root;
    logic                  room1;
    logic                  room2;
    logic                  is_map;
    logic [ENTRY_W-1:0]    ptr_entry;

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshake and decode helpers
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign ent_valid = mem_rdata[0];
    assign ent_child = mem_rdata[FLAG_W +: FRAME_W];
    assign root      = root_frame(root_sel_reg);
    assign is_map    = (req_type_reg == REQ_MAP);
    assign room1     = ({1'b0, free_reg} + (FREE_W + 1)'(1)) <= FRAMES_LIMIT;
    assign room2     = ({1'b0, free_reg} + (FREE_W + 1)'(2)) <= FRAMES_LIMIT;
    // New pointer entry to the next free frame, valid bit set
    assign ptr_entry = {(PPN_W - FRAME_W)'(0), free_reg[FRAME_W-1:0],
                        (FLAG_W - 1)'(0), 1'b1};

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.translated_addr = out_addr_reg;
    assign rsp.found_flags     = out_flags_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == STORE_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                if (is_map)
                begin
                    if (ent_valid)
                    begin
                        state_next = S_CHK1;
                    end
                    else if (room2)
                    begin
                        state_next = S_WR1;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    state_next = ent_valid ? S_CHK1 : S_RESP;
                end
            end
            S_CHK1:
            begin
                if (is_map)
                begin
                    if (ent_valid)
                    begin
                        state_next = S_WR0;
                    end
                    else if (room1)
                    begin
                        state_next = S_WR1;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    state_next = ent_valid ? S_CHK0 : S_RESP;
                end
            end
            S_CHK0:
            begin
                state_next = S_RESP;
            end
            S_WR1:
            begin
                state_next = S_WR0;
            end
            S_WR0:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Datapath and store port control
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = clr_cnt_reg;
        mem_wdata       = '0;
        mem_raddr       = {root, vpn(va_reg, 2)};
        clr_cnt_next    = clr_cnt_reg;
        free_next       = free_reg;
        frame_next      = frame_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_flags_next  = res_flags_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
            end
            S_IDLE:
            begin
                res_status_next = ST_OK;
                res_addr_next   = '0;
                res_flags_next  = '0;
            end
            S_RD2:
            begin
                // read address already on the port
            end
            S_CHK2:
            begin
                mem_raddr = {ent_child, vpn(va_reg, 1)};
                if (is_map)
                begin
                    if (ent_valid)
                    begin
                        frame_next = ent_child;
                    end
                    else if (room2)
                    begin
                        // new level-1 table; its entries are all invalid
                        mem_we     = 1'b1;
                        mem_waddr  = {root, vpn(va_reg, 2)};
                        mem_wdata  = ptr_entry;
                        frame_next = free_reg[FRAME_W-1:0];
                        free_next  = free_reg + FREE_W'(1);
                    end
                    else
                    begin
                        res_status_next = ST_NO_FRAME;
                    end
                end
                else if (!ent_valid)
                begin
                    res_status_next = ST_NOT_MAPPED;
                end
            end
            S_CHK1:
            begin
                mem_raddr = {ent_child, vpn(va_reg, 0)};
                if (is_map)
                begin
                    if (ent_valid)
                    begin
                        frame_next = ent_child;
                    end
                    else if (!room1)
                    begin
                        res_status_next = ST_NO_FRAME;
                    end
                end
                else if (!ent_valid)
                begin
                    res_status_next = ST_NOT_MAPPED;
                end
            end
            S_CHK0:
            begin
                if (ent_valid)
                begin
                    res_addr_next  = {mem_rdata[FLAG_W +: PPN_W], va_reg[OFS_W-1:0]};
                    res_flags_next = mem_rdata[FLAG_W-1:0];
                end
                else
                begin
                    res_status_next = ST_NOT_MAPPED;
                end
            end
            S_WR1:
            begin
                // link a new level-0 table into the level-1 table
                mem_we     = 1'b1;
                mem_waddr  = {frame_reg, vpn(va_reg, 1)};
                mem_wdata  = ptr_entry;
                frame_next = free_reg[FRAME_W-1:0];
                free_next  = free_reg + FREE_W'(1);
            end
            S_WR0:
            begin
                mem_we    = 1'b1;
                mem_waddr = {frame_reg, vpn(va_reg, 0)};
                mem_wdata = {pa_ppn_reg, flags_reg};
            end
            S_RESP:
            begin
                // result moves to the output register
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            free_reg      <= FREE_RESET;
            root_sel_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            free_reg    <= free_next;
            if (cfg_we)
            begin
                root_sel_reg <= cfg_wdata;
            end
            if (state_reg == S_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_flags_reg  <= res_flags_next;
        if (req_fire)
        begin
            req_type_reg <= req.req_type;
            va_reg       <= req.virt_addr;
            pa_ppn_reg   <= req.phys_addr[PA_W-1:OFS_W];
            flags_reg    <= req.pte_flags;
        end
        if (state_reg == S_RESP && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_flags_reg  <= res_flags_reg;
        end
    end

    // Checks
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, free_reg} <= FRAMES_LIMIT)
        else $error("frame allocator ran past the table store");

    a_lookup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLEAR) |-> (req_type_reg == REQ_MAP))
        else $error("table store written during a lookup");

    a_no_frame_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && res_status_reg == ST_NO_FRAME) |-> $stable(free_reg))
        else $error("rejected map changed the allocator");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_NOT_MAPPED
                       || rsp.status == ST_NO_FRAME))
        else $error("response carries an unknown status code");

endmodule

`default_nettype wire

@@ test/sv39_page_table_walker_core_tb.sv @@
// Self-checking testbench for the Sv39 page table walker core: map and lookup requests.

module sv39_page_table_walker_core_tb;
    import ptw_pkg::*;

    typedef struct {
        logic              req_type;
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [FLAG_W-1:0] pte_flags;
    } walk_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PA_W-1:0]     translated_addr;
        logic [FLAG_W-1:0]   found_flags;
    } walk_answer_t;

    // Mirror of the page tables plus the queue of answers still owed by the block
    class translation_checker;
        bit [ENTRY_W-1:0]    page_tables [STORE_DEPTH];
        int unsigned         next_frame;
        bit [ROOT_SEL_W-1:0] root_sel;
        walk_answer_t        expected_answers [$];
        int                  errors;

        function new();
            next_frame = ROOT_FRAMES;
            root_sel   = '0;
            errors     = 0;
        endfunction

        function void set_root(bit [ROOT_SEL_W-1:0] value);
            root_sel = value;
        endfunction

        function int entry_slot(int frame, logic [IDX_W-1:0] idx);
            return (frame % TABLE_FRAMES) * TABLE_ENTRIES + int'(idx);
        endfunction

        function logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va, int level);
            return va[OFS_W + IDX_W * level +: IDX_W];
        endfunction

        function int child_frame(bit [ENTRY_W-1:0] entry);
            return int'(entry[ENTRY_W-1:FLAG_W] % TABLE_FRAMES);
        endfunction

        // Walk the mirrored tables for one accepted request and queue its answer
        function void predict_walk(walk_request_t rq);
            walk_answer_t     ans;
            int               root;
            int               s2;
            int               s1;
            int               l1;
            int               l0;
            int               need;
            bit [ENTRY_W-1:0] e2;
            bit [ENTRY_W-1:0] e1;
            bit [ENTRY_W-1:0] e0;
            ans.status          = ST_OK;
            ans.translated_addr = '0;
            ans.found_flags     = '0;
            root = int'(root_sel) % ROOT_FRAMES;
            s2   = entry_slot(root, level_index(rq.virt_addr, 2));
            e2   = page_tables[s2];
            if (rq.req_type == REQ_MAP)
            begin
                need = 0;
                if (!e2[0])
                begin
                    need = 2;
                end
                else if (!page_tables[entry_slot(child_frame(e2),
                                                 level_index(rq.virt_addr, 1))][0])
                begin
                    need = 1;
                end
                if (next_frame + need > TABLE_FRAMES)
                begin
                    // not enough frames: nothing written, nothing allocated
                    ans.status = ST_NO_FRAME;
                end
                else
                begin
                    if (!e2[0])
                    begin
                        l1 = next_frame;
                        next_frame++;
                        page_tables[s2] = (ENTRY_W'(l1) << FLAG_W) | ENTRY_W'(1);
                    end
                    else
                    begin
                        l1 = child_frame(e2);
                    end
                    s1 = entry_slot(l1, level_index(rq.virt_addr, 1));
                    if (!page_tables[s1][0])
                    begin
                        l0 = next_frame;
                        next_frame++;
                        page_tables[s1] = (ENTRY_W'(l0) << FLAG_W) | ENTRY_W'(1);
                    end
                    else
                    begin
                        l0 = child_frame(page_tables[s1]);
                    end
                    // leaf is written even when its valid bit is clear
                    page_tables[entry_slot(l0, level_index(rq.virt_addr, 0))] =
                        {rq.phys_addr[PA_W-1:OFS_W], rq.pte_flags};
                end
            end
            else
            begin
                if (!e2[0])
                begin
                    ans.status = ST_NOT_MAPPED;
                end
                else
                begin
                    e1 = page_tables[entry_slot(child_frame(e2), level_index(rq.virt_addr, 1))];
                    if (!e1[0])
                    begin
                        ans.status = ST_NOT_MAPPED;
                    end
                    else
                    begin
                        e0 = page_tables[entry_slot(child_frame(e1),
                                                    level_index(rq.virt_addr, 0))];
                        if (!e0[0])
                        begin
                            ans.status = ST_NOT_MAPPED;
                        end
                        else
                        begin
                            ans.translated_addr = {e0[ENTRY_W-1:FLAG_W],
                                                   rq.virt_addr[OFS_W-1:0]};
                            ans.found_flags     = e0[FLAG_W-1:0];
                        end
                    end
                end
            end
            expected_answers.push_back(ans);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted answer with the oldest one owed
        task check_answer(logic [STATUS_W-1:0] st, logic [PA_W-1:0] ta,
                          logic [FLAG_W-1:0] ff);
            walk_answer_t want;
            if (expected_answers.size() == 0)
            begin
                report_mismatch("answer with no request outstanding");
                return;
            end
            want = expected_answers.pop_front();
            if (st !== want.status)
            begin
                report_mismatch($sformatf("status %0d, want %0d", st, want.status));
            end
            if (ta !== want.translated_addr)
            begin
                report_mismatch($sformatf("translated_addr %h, want %h",
                                          ta, want.translated_addr));
            end
            if (ff !== want.found_flags)
            begin
                report_mismatch($sformatf("found_flags %h, want %h", ff, want.found_flags));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [ROOT_SEL_W-1:0] cfg_wdata;

    ptw_req_if req ();
    ptw_rsp_if rsp ();

    sv39_page_table_walker_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    translation_checker chk;
    logic [VA_W-1:0]    mapped_va [$];
    logic [IDX_W-1:0]   top_pool [6];
    logic [IDX_W-1:0]   mid_pool [4];
    bit                 hold_due;
    int                 send_calm_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop if the block hangs
    initial
    begin : watchdog
        #(20 * 600000);
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly addresses from small index pools so tables get reused; some fully random
    function automatic logic [VA_W-1:0] pick_va();
        logic [VA_W-1:0] va;
        va = VA_W'({$urandom, $urandom});
        if ($urandom_range(0, 4) != 0)
        begin
            va[OFS_W + 2 * IDX_W +: IDX_W] = top_pool[$urandom_range(0, 5)];
            va[OFS_W + IDX_W +: IDX_W]     = mid_pool[$urandom_range(0, 3)];
        end
        return va;
    endfunction

    function automatic walk_request_t random_request();
        walk_request_t rq;
        rq.req_type  = ($urandom_range(0, 99) < 55) ? REQ_MAP : REQ_LOOKUP;
        rq.virt_addr = pick_va();
        rq.phys_addr = PA_W'({$urandom, $urandom});
        rq.pte_flags = FLAG_W'($urandom);
        if (rq.req_type == REQ_MAP)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                rq.pte_flags[0] = 1'b1;
            end
            mapped_va.push_back(rq.virt_addr);
        end
        else if (mapped_va.size() > 0 && $urandom_range(0, 99) < 60)
        begin
            // look up an address mapped earlier, with a fresh page offset
            rq.virt_addr = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
            rq.virt_addr[OFS_W-1:0] = OFS_W'($urandom);
        end
        return rq;
    endfunction

    // Offer one request after a random gap; predict once it is accepted
    task automatic send_request(input walk_request_t rq);
        int gap;
        if (send_calm_left > 0)
        begin
            gap = 0;
            send_calm_left--;
        end
        else
        begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 29) == 0)
            begin
                send_calm_left = $urandom_range(10, 30);
            end
        end
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= rq.req_type;
        req.virt_addr <= rq.virt_addr;
        req.phys_addr <= rq.phys_addr;
        req.pte_flags <= rq.pte_flags;
        do
        begin
            @(posedge clk);
        end
        while (req.ready !== 1'b1);
        chk.predict_walk(rq);
    endtask

    task automatic directed(input logic kind, input logic [VA_W-1:0] va,
                            input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] flags);
        walk_request_t rq;
        rq.req_type  = kind;
        rq.virt_addr = va;
        rq.phys_addr = pa;
        rq.pte_flags = flags;
        send_request(rq);
    endtask

    task automatic write_root(input logic [ROOT_SEL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chk.set_root(value);
    endtask

    // Wait until every owed answer is in, then let the walk settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (chk.expected_answers.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    // Answer side: random stalls, calm stretches, and one long hold-off
    initial
    begin : answer_side
        int stall;
        int calm_left;
        calm_left = 0;
        @(posedge clk);
        forever
        begin
            if (hold_due)
            begin
                stall    = 300;
                hold_due = 1'b0;
            end
            else if (calm_left > 0)
            begin
                stall = 0;
                calm_left--;
            end
            else
            begin
                stall = $urandom_range(0, 15);
                if ($urandom_range(0, 29) == 0)
                begin
                    calm_left = $urandom_range(10, 30);
                end
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (rsp.valid !== 1'b1);
            chk.check_answer(rsp.status, rsp.translated_addr, rsp.found_flags);
        end
    end

    // Stimulus: reset, directed requests, then random phases under several roots
    initial
    begin : stimulus
        int root_plan [6];
        req.valid     <= 1'b0;
        req.req_type  <= REQ_MAP;
        req.virt_addr <= '0;
        req.phys_addr <= '0;
        req.pte_flags <= '0;
        rsp.ready     <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rst_n         <= 1'b0;
        hold_due       = 1'b0;
        send_calm_left = 0;
        chk = new();
        root_plan = '{0, 3, 1, 2, 3, 0};
        top_pool[0] = '0;
        top_pool[1] = '1;
        mid_pool[0] = '0;
        mid_pool[1] = '1;
        for (int i = 2; i < 6; i++)
        begin
            top_pool[i] = IDX_W'($urandom);
        end
        for (int i = 2; i < 4; i++)
        begin
            mid_pool[i] = IDX_W'($urandom);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_root(ROOT_SEL_W'(root_plan[0]));

        // empty tables, extremes, invalid leaf, misses at each level, remap
        directed(REQ_LOOKUP, '0, '0, '0);
        directed(REQ_MAP, '0, '0, 10'h001);
        directed(REQ_LOOKUP, 39'hFFF, '0, '0);
        directed(REQ_MAP, '1, '1, '1);
        directed(REQ_LOOKUP, '1, '0, '0);
        directed(REQ_MAP, 39'h1000, 56'h00_1234_5678_9ABC, 10'h3FE);
        directed(REQ_LOOKUP, 39'h1000, '1, '1);
        directed(REQ_MAP, 39'h1 << 21, 56'hA5_A5A5_A5A5_AFFF, 10'h0CF);
        directed(REQ_LOOKUP, (39'h1 << 21) | 39'h123, '0, '0);
        directed(REQ_LOOKUP, 39'h1 << 30, '0, '0);
        directed(REQ_LOOKUP, 39'h2 << 21, '0, '0);
        directed(REQ_LOOKUP, (39'h1 << 21) | (39'h5 << 12), '0, '0);
        directed(REQ_MAP, '0, 56'h5A_5A5A_5A5A_5000, 10'h2AB);
        directed(REQ_LOOKUP, 39'hABC, '0, '0);
        directed(REQ_MAP, 39'h40_0000_0000, 56'h80_0000_0000_0000, 10'h201);
        directed(REQ_LOOKUP, 39'h40_0000_0FFF, '0, '0);
        mapped_va.push_back('0);
        mapped_va.push_back('1);
        req.valid <= 1'b0;

        for (int phase = 1; phase < 6; phase++)
        begin
            wait_idle();
            write_root(ROOT_SEL_W'(root_plan[phase]));
            if (phase == 2)
            begin
                hold_due = 1'b1;
            end
            repeat (107) send_request(random_request());
            req.valid <= 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (chk.expected_answers.size() != 0)
        begin
            chk.report_mismatch($sformatf("%0d answers never arrived",
                                          chk.expected_answers.size()));
        end
        if (chk.errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ptw_pkg.sv
src/ptw_if.sv
src/ptw_ram.sv
src/sv39_page_table_walker_core.sv
test/sv39_page_table_walker_core_tb.sv
